[rtl/srfc_pkg.sv]
// Shared types and constants of the sensor response frame checker.
// Used by the interfaces, the frame tracker, the result register and the top level.
`default_nettype none

package srfc_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned POS_W   = 5;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned HDR_CNT = 4;

	localparam logic [POS_W-1:0] POS_HDR_LAST    = POS_W'(3);
	localparam logic [POS_W-1:0] POS_CMD         = POS_W'(4);
	localparam logic [POS_W-1:0] POS_LEN         = POS_W'(5);
	localparam logic [POS_W-1:0] POS_ALPHA_FIRST = POS_W'(6);
	localparam logic [POS_W-1:0] POS_ALPHA_LAST  = POS_W'(9);
	localparam logic [POS_W-1:0] POS_BETA_FIRST  = POS_W'(10);
	localparam logic [POS_W-1:0] POS_BETA_LAST   = POS_W'(13);
	localparam logic [POS_W-1:0] POS_ERROR       = POS_W'(14);
	localparam logic [POS_W-1:0] POS_CHECK       = POS_W'(15);
	localparam logic [POS_W-1:0] POS_IDLE        = POS_W'(16);

	localparam logic [BYTE_W-1:0] CMD_EXPECTED = 8'h01;
	localparam logic [BYTE_W-1:0] LEN_EXPECTED = 8'h0A;

	localparam logic [CFG_IDX_W-1:0] REG_HDR0 = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HDR1 = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_HDR2 = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_HDR3 = CFG_IDX_W'(3);

	typedef enum logic [1:0] {
		FAULT_NONE   = 2'd0,
		FAULT_HEADER = 2'd1,
		FAULT_FIELDS = 2'd2,
		FAULT_SUM    = 2'd3
	} fault_t;

	typedef struct packed {
		fault_t              fault;
		logic [WORD_W-1:0]   alpha;
		logic [WORD_W-1:0]   beta;
		logic [BYTE_W-1:0]   err;
	} res_t;

endpackage

`default_nettype wire

[rtl/srfc_if.sv]
// Valid/ready channel interfaces for received bytes and frame results.
// Depends on srfc_pkg for field widths.
`default_nettype none

interface srfc_rx_if;
	logic                          valid;
	logic                          ready;
	logic [srfc_pkg::BYTE_W-1:0]   rx_byte;
	logic                          frame_start;

	modport source (output valid, output rx_byte, output frame_start, input ready);
	modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface srfc_res_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    frame_fault;
	logic [srfc_pkg::WORD_W-1:0]   alpha_bits;
	logic [srfc_pkg::WORD_W-1:0]   beta_bits;
	logic [srfc_pkg::BYTE_W-1:0]   sensor_error;

	modport source (output valid, output frame_fault, output alpha_bits, output beta_bits,
		output sensor_error, input ready);
	modport sink (input valid, input frame_fault, input alpha_bits, input beta_bits,
		input sensor_error, output ready);
endinterface

`default_nettype wire

[rtl/srfc_frame_track.sv]
// Frame tracker: header registers, byte position, running checksum and payload assembly.
// Produces one result at the last byte of a frame. Depends on srfc_pkg.
`default_nettype none

module srfc_frame_track (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [srfc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [srfc_pkg::BYTE_W-1:0]       cfg_data,
	input  wire logic                              take,
	input  wire logic [srfc_pkg::BYTE_W-1:0]       rx_byte,
	input  wire logic                              frame_start,
	output      logic                              res_load,
	output      srfc_pkg::res_t                    res
);

	logic [srfc_pkg::BYTE_W-1:0] hdr_q [srfc_pkg::HDR_CNT];
	logic [srfc_pkg::POS_W-1:0]  pos_q;
	logic                        hdr_good_q;
	logic                        fld_good_q;
	logic [srfc_pkg::BYTE_W-1:0] sum_q;
	logic [srfc_pkg::WORD_W-1:0] alpha_q;
	logic [srfc_pkg::WORD_W-1:0] beta_q;
	logic [srfc_pkg::BYTE_W-1:0] err_q;

	logic                        active;
	logic [srfc_pkg::POS_W-1:0]  cur_pos;
	logic                        hdr_good_d;
	logic                        fld_good_d;
	logic [srfc_pkg::BYTE_W-1:0] sum_base;
	logic [srfc_pkg::BYTE_W-1:0] sum_d;
	logic [srfc_pkg::WORD_W-1:0] alpha_d;
	logic [srfc_pkg::WORD_W-1:0] beta_d;
	logic [srfc_pkg::BYTE_W-1:0] err_d;
	logic                        step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < srfc_pkg::HDR_CNT; i++) begin
				hdr_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				srfc_pkg::REG_HDR0: hdr_q[0] <= cfg_data;
				srfc_pkg::REG_HDR1: hdr_q[1] <= cfg_data;
				srfc_pkg::REG_HDR2: hdr_q[2] <= cfg_data;
				srfc_pkg::REG_HDR3: hdr_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// A start flag opens a new frame whatever was open before.
	always_comb begin
		active     = frame_start || (pos_q < srfc_pkg::POS_IDLE);
		cur_pos    = frame_start ? '0 : pos_q;
		hdr_good_d = frame_start ? 1'b1 : hdr_good_q;
		fld_good_d = frame_start ? 1'b1 : fld_good_q;
		sum_base   = frame_start ? '0 : sum_q;
		sum_d      = sum_base;
		alpha_d    = alpha_q;
		beta_d     = beta_q;
		err_d      = err_q;

		if (cur_pos <= srfc_pkg::POS_HDR_LAST) begin
			if (rx_byte != hdr_q[cur_pos[1:0]]) begin
				hdr_good_d = 1'b0;
			end
		end else if (cur_pos == srfc_pkg::POS_CMD) begin
			if (rx_byte != srfc_pkg::CMD_EXPECTED) begin
				fld_good_d = 1'b0;
			end
		end else if (cur_pos == srfc_pkg::POS_LEN) begin
			if (rx_byte != srfc_pkg::LEN_EXPECTED) begin
				fld_good_d = 1'b0;
			end
		end else if (cur_pos inside {[srfc_pkg::POS_ALPHA_FIRST:srfc_pkg::POS_ALPHA_LAST]}) begin
			alpha_d = {rx_byte, alpha_q[srfc_pkg::WORD_W-1:srfc_pkg::BYTE_W]};
		end else if (cur_pos inside {[srfc_pkg::POS_BETA_FIRST:srfc_pkg::POS_BETA_LAST]}) begin
			beta_d = {rx_byte, beta_q[srfc_pkg::WORD_W-1:srfc_pkg::BYTE_W]};
		end else if (cur_pos == srfc_pkg::POS_ERROR) begin
			err_d = rx_byte;
		end

		if (cur_pos inside {[srfc_pkg::POS_CMD:srfc_pkg::POS_ERROR]}) begin
			sum_d = sum_base + rx_byte;
		end
	end

	assign step = take && active;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= srfc_pkg::POS_IDLE;
			hdr_good_q <= 1'b1;
			fld_good_q <= 1'b1;
		end else if (step) begin
			pos_q      <= srfc_pkg::POS_W'(cur_pos + srfc_pkg::POS_W'(1));
			hdr_good_q <= hdr_good_d;
			fld_good_q <= fld_good_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			sum_q   <= sum_d;
			alpha_q <= frame_start ? '0 : alpha_d;
			beta_q  <= frame_start ? '0 : beta_d;
			err_q   <= frame_start ? '0 : err_d;
		end
	end

	always_comb begin
		res_load = step && (cur_pos == srfc_pkg::POS_CHECK);
		if (!hdr_good_d) begin
			res.fault = srfc_pkg::FAULT_HEADER;
		end else if (!fld_good_d) begin
			res.fault = srfc_pkg::FAULT_FIELDS;
		end else if (rx_byte != sum_base) begin
			res.fault = srfc_pkg::FAULT_SUM;
		end else begin
			res.fault = srfc_pkg::FAULT_NONE;
		end
		if (res.fault == srfc_pkg::FAULT_NONE) begin
			res.alpha = alpha_q;
			res.beta  = beta_q;
			res.err   = err_q;
		end else begin
			res.alpha = '0;
			res.beta  = '0;
			res.err   = '0;
		end
	end

endmodule

`default_nettype wire

[rtl/srfc_out_reg.sv]
// Result register: holds one finished result until the receiver takes it.
// Depends on srfc_pkg for the result type.
`default_nettype none

module srfc_out_reg (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            load,
	input  wire srfc_pkg::res_t  d,
	input  wire logic            ready,
	output      logic            valid,
	output      srfc_pkg::res_t  q,
	output      logic            can_take
);

	logic           valid_q;
	srfc_pkg::res_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= d;
		end
	end

	assign valid    = valid_q;
	assign q        = data_q;
	assign can_take = !valid_q || ready;

endmodule

`default_nettype wire

[rtl/sensor_response_frame_checker.sv]
// Top level of the sun-angle sensor response frame checker.
// Instantiates srfc_frame_track and srfc_out_reg; uses srfc_pkg and the channel interfaces.
//
// The rx channel carries one response byte per item, with frame_start high on the
// first byte of a 16-byte frame. Bytes outside an open frame are dropped without
// a result, and a start flag inside a frame abandons it.
// The res channel carries one item per complete frame: the fault code and, for a
// good frame, alpha, beta and the sensor error code (all zero for a faulty frame).
// The configuration port writes the four expected header bytes at indices 0 to 3.
// Each byte is handled in the cycle it is accepted, so one byte per cycle is taken
// continuously unless the result register is full and not being taken. The result
// appears on res in the cycle after the last byte of the frame is accepted, from a single result register.
// When the receiver stalls, rx stays ready until the result register is full and
// not being taken; then rx waits until res ready is high.
// Reset clears the header registers to zero, closes any open frame and empties
// the result register.
`default_nettype none

module sensor_response_frame_checker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [srfc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [srfc_pkg::BYTE_W-1:0]       cfg_data,
	srfc_rx_if.sink                                rx,
	srfc_res_if.source                             res
);

	logic           take;
	logic           can_take;
	logic           res_load;
	srfc_pkg::res_t res_d;
	srfc_pkg::res_t res_q;

	assign rx.ready = can_take;
	assign take     = rx.valid && can_take;

	srfc_frame_track u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.take        (take),
		.rx_byte     (rx.rx_byte),
		.frame_start (rx.frame_start),
		.res_load    (res_load),
		.res         (res_d)
	);

	srfc_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (res_load),
		.d        (res_d),
		.ready    (res.ready),
		.valid    (res.valid),
		.q        (res_q),
		.can_take (can_take)
	);

	assign res.frame_fault  = res_q.fault;
	assign res.alpha_bits   = res_q.alpha;
	assign res.beta_bits    = res_q.beta;
	assign res.sensor_error = res_q.err;

endmodule

`default_nettype wire

[rtl/srfc_chk.sv]
// Port-level checker for the sensor response frame checker, bound to the top level.
// Depends on srfc_pkg and the channel interfaces of the top level.
`default_nettype none

module srfc_chk (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            rx_valid,
	input wire logic                            rx_ready,
	input wire logic                            res_valid,
	input wire logic                            res_ready,
	input wire logic [1:0]                      frame_fault,
	input wire logic [srfc_pkg::WORD_W-1:0]     alpha_bits,
	input wire logic [srfc_pkg::WORD_W-1:0]     beta_bits,
	input wire logic [srfc_pkg::BYTE_W-1:0]     sensor_error
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("Result item dropped while stalled.");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(frame_fault) && $stable(alpha_bits)
			&& $stable(beta_bits) && $stable(sensor_error))
		else $error("Result item changed while stalled.");

	a_fault_clears: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_fault != srfc_pkg::FAULT_NONE |->
			alpha_bits == '0 && beta_bits == '0 && sensor_error == '0)
		else $error("Faulty frame carries payload.");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> rx_ready)
		else $error("Byte refused with an empty result register.");

	a_res_from_byte: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(rx_valid && rx_ready))
		else $error("Result item appeared without an accepted byte.");

endmodule

bind sensor_response_frame_checker srfc_chk u_srfc_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.rx_valid     (rx.valid),
	.rx_ready     (rx.ready),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.frame_fault  (res.frame_fault),
	.alpha_bits   (res.alpha_bits),
	.beta_bits    (res.beta_bits),
	.sensor_error (res.sensor_error)
);

`default_nettype wire
